FILE: src/teleop_ramp_limited_command_macros.svh
// Assertion macros for the checker file.
`ifndef TELEOP_RAMP_LIMITED_COMMAND_MACROS_SVH
`define TELEOP_RAMP_LIMITED_COMMAND_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define TRLC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds through reset.
`define TRLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/trlc_pkg.sv
package trlc_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] REG_MAX_FWD_SPEED   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_REV_SPEED   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_STEER_RIGHT = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_STEER_LEFT  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_FWD_STEP        = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_REV_STEP        = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_STEER_RIGHT_STEP = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_STEER_LEFT_STEP = 3'd7;

   localparam logic [15:0] STEER_AT_SPEED = 16'd2000;
   localparam logic [13:0] STEER_MAG_MAX  = 14'd9000;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [15:0] max_fwd_speed;
      logic [15:0] max_rev_speed;
      logic [13:0] max_steer_right;
      logic [13:0] max_steer_left;
      logic [15:0] fwd_step;
      logic [15:0] rev_step;
      logic [13:0] steer_right_step;
      logic [13:0] steer_left_step;
   } trlc_cfg_type;

   // Classified request: everything the state recurrence needs, pre-scaled.
   typedef struct packed {
      logic        speed_neg;
      logic        steer_right;
      logic [15:0] spd_grow;
      logic [15:0] spd_cap;
      logic [17:0] spd_thr;
      logic [13:0] str_grow;
      logic [13:0] str_cap;
      logic [13:0] str_cap_fast;
   } trlc_item_type;

   // v * mag / 32768, rounded half up; mag is at most 32768 so it fits 16 bits
   function automatic logic [15:0] trlc_scale(input logic [16:0] mag, input logic [15:0] v);
      logic [33:0] prod;
      prod = 34'(mag) * 34'(v) + 34'd16384;
      return prod[30:15];
   endfunction

endpackage

FILE: src/trlc_csr.sv
module trlc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [trlc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [trlc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output trlc_pkg::trlc_cfg_type            cfg
);
   import trlc_pkg::*;

   trlc_cfg_type cfg_ff;
   trlc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_MAX_FWD_SPEED:    cfg_in.max_fwd_speed    = csr_wdata;
            REG_MAX_REV_SPEED:    cfg_in.max_rev_speed    = csr_wdata;
            REG_MAX_STEER_RIGHT:  cfg_in.max_steer_right  = csr_wdata[13:0];
            REG_MAX_STEER_LEFT:   cfg_in.max_steer_left   = csr_wdata[13:0];
            REG_FWD_STEP:         cfg_in.fwd_step         = csr_wdata;
            REG_REV_STEP:         cfg_in.rev_step         = csr_wdata;
            REG_STEER_RIGHT_STEP: cfg_in.steer_right_step = csr_wdata[13:0];
            REG_STEER_LEFT_STEP:  cfg_in.steer_left_step  = csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_fwd_speed    <= 16'd10000;
         cfg_ff.max_rev_speed    <= 16'd10000;
         cfg_ff.max_steer_right  <= 14'd2500;
         cfg_ff.max_steer_left   <= 14'd2500;
         cfg_ff.fwd_step         <= 16'd20;
         cfg_ff.rev_step         <= 16'd20;
         cfg_ff.steer_right_step <= 14'd2;
         cfg_ff.steer_left_step  <= 14'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/trlc_front.sv
module trlc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  trlc_pkg::trlc_cfg_type   cfg,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [31:0]              req_tdata,
   input  logic                     q_full,
   output logic                     q_push,
   output trlc_pkg::trlc_item_type  q_push_item
);
   import trlc_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   trlc_item_type item_ff;
   trlc_item_type item_in;

   logic signed [16:0] spd_ext;
   logic signed [16:0] str_ext;
   logic [16:0]        spd_mag;
   logic [16:0]        str_mag;
   logic               fwd;
   logic               right;
   logic [15:0]        str_grow_w;
   logic [15:0]        str_cap_w;
   logic [15:0]        str_fast_w;
   logic               accept;

   assign q_push     = valid_ff && !q_full;
   assign req_tready = !valid_ff || !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      spd_ext = 17'(signed'(req_tdata[15:0]));
      str_ext = 17'(signed'(req_tdata[31:16]));
      spd_mag = spd_ext[16] ? 17'(-spd_ext) : 17'(spd_ext);
      str_mag = str_ext[16] ? 17'(-str_ext) : 17'(str_ext);
      // zero stick selects the reverse and left registers
      fwd     = !spd_ext[16] && (spd_ext != 17'sd0);
      right   = !str_ext[16] && (str_ext != 17'sd0);

      str_grow_w = trlc_scale(str_mag,
                              {2'b00, right ? cfg.steer_right_step : cfg.steer_left_step});
      str_cap_w  = trlc_scale(str_mag,
                              {2'b00, right ? cfg.max_steer_right : cfg.max_steer_left});
      str_fast_w = trlc_scale(str_mag, STEER_AT_SPEED);

      item_in.speed_neg    = spd_ext[16];
      item_in.steer_right  = right;
      item_in.spd_grow     = trlc_scale(spd_mag, fwd ? cfg.fwd_step : cfg.rev_step);
      item_in.spd_cap      = trlc_scale(spd_mag, fwd ? cfg.max_fwd_speed : cfg.max_rev_speed);
      item_in.spd_thr      = {spd_ext[16] ? cfg.max_rev_speed : cfg.max_fwd_speed, 2'b00};
      item_in.str_grow     = str_grow_w[13:0];
      item_in.str_cap      = str_cap_w[13:0];
      item_in.str_cap_fast = str_fast_w[13:0];

      valid_in = accept || (valid_ff && q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign q_push_item = item_ff;

endmodule

FILE: src/trlc_queue.sv
module trlc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  trlc_pkg::trlc_item_type  push_item,
   output logic                     full,
   input  logic                     pop,
   output logic                     valid,
   output trlc_pkg::trlc_item_type  item
);
   import trlc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   trlc_item_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/trlc_back.sv
module trlc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  trlc_pkg::trlc_item_type  q_item,
   output logic                     q_pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [31:0]              rsp_tdata
);
   import trlc_pkg::*;

   logic [15:0] spd_mag_ff, spd_mag_in;
   logic [13:0] str_mag_ff, str_mag_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_data_ff, out_data_in;

   logic [16:0] spd_sum;
   logic [16:0] spd_min;
   logic [18:0] spd_five;
   logic        at_speed;
   logic [14:0] str_sum;
   logic [13:0] str_cap_sel;
   logic [14:0] str_min;
   logic [16:0] speed_cmd;
   logic [14:0] steer_cmd;

   assign q_pop = q_valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      spd_sum = {1'b0, spd_mag_ff} + {1'b0, q_item.spd_grow};
      // the cap is never above 65535, so the minimum is already in range
      spd_min = (spd_sum < {1'b0, q_item.spd_cap}) ? spd_sum : {1'b0, q_item.spd_cap};
      spd_mag_in = spd_min[15:0];

      spd_five = {1'b0, spd_mag_in, 2'b00} + {3'b000, spd_mag_in};
      at_speed = (spd_mag_in != '0) && (spd_five >= {1'b0, q_item.spd_thr});

      str_sum     = {1'b0, str_mag_ff} + {1'b0, q_item.str_grow};
      str_cap_sel = at_speed ? q_item.str_cap_fast : q_item.str_cap;
      str_min     = (str_sum < {1'b0, str_cap_sel}) ? str_sum : {1'b0, str_cap_sel};
      str_mag_in  = (str_min > {1'b0, STEER_MAG_MAX}) ? STEER_MAG_MAX : str_min[13:0];

      speed_cmd = q_item.speed_neg ? 17'(-{1'b0, spd_mag_in}) : {1'b0, spd_mag_in};
      steer_cmd = q_item.steer_right ? 15'(-{1'b0, str_mag_in}) : {1'b0, str_mag_in};

      out_data_in  = {steer_cmd, speed_cmd};
      out_valid_in = q_pop || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spd_mag_ff   <= '0;
         str_mag_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (q_pop) begin
            spd_mag_ff <= spd_mag_in;
            str_mag_ff <= str_mag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

FILE: src/teleop_ramp_limited_command.sv
// Channel   Direction  tdata, lowest bit up                          Sideband
// req_      in         speed_axis[15:0] s16, steer_axis[31:16] s16      none
// rsp_      out        speed_command[16:0] s17, steer_command[31:17] s15 none
// csr_      in         we, addr[2:0], wdata[15:0]; no read-back         none
//
// One request per clock sustained while rsp_tready is high. Requests pass the front
// register and the queue to the output register. The front stage scales each stick by
// its direction's step and cap; the back stage closes the speed and steer ramp on the
// previous magnitudes. A two-entry queue parts the stages; req_tready drops only when
// front and queue are full. Synchronous reset clears the queue, the output valid and
// both ramp states, and loads the registers with their defaults.
module teleop_ramp_limited_command (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [31:0]                             req_tdata,   // speed_axis, steer_axis
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [31:0]                             rsp_tdata,   // speed_command, steer_command
   input  logic                                    csr_we,
   input  logic [trlc_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  logic [trlc_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import trlc_pkg::*;

   trlc_cfg_type  cfg;
   trlc_item_type push_item;
   trlc_item_type head_item;
   logic          q_full;
   logic          q_push;
   logic          q_valid;
   logic          q_pop;

   trlc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   trlc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_item (push_item)
   );

   trlc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .item      (head_item)
   );

   trlc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: src/trlc_checker.sv
`include "teleop_ramp_limited_command_macros.svh"

module trlc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [31:0]                         req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [31:0]                         rsp_tdata,
   input logic                                csr_we,
   input logic [trlc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input logic [trlc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // hold a stalled result
   `TRLC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `TRLC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "result valid after reset")

   `TRLC_ASSERT(a_steer_range, clock, reset, rsp_tvalid |-> ($signed(rsp_tdata[31:17]) <= 15'sd9000) && ($signed(rsp_tdata[31:17]) >= -15'sd9000), "steer command out of range")

   `TRLC_ASSERT(a_speed_range, clock, reset, rsp_tvalid |-> rsp_tdata[16:0] != 17'h10000, "speed command out of range")

endmodule

bind teleop_ramp_limited_command trlc_checker u_trlc_checker (.*);
